>>> rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared widths, codes, memory word layouts and the controller/datapath
// command and status bundles of the first-fit slot allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int CAP_W           = 11;
    localparam int KEY_W           = 16;
    localparam int STATUS_W        = 3;
    localparam int MAX_SLOTS       = 1024;
    localparam int MAX_FREE_RANGES = 512;
    localparam int MAX_OWNERS      = 1024;
    localparam int CAP_RESET       = 1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED  = 3'd0,
        ST_NO_ROOM    = 3'd1,
        ST_RELEASED   = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_BAD_LENGTH = 3'd4
    } t_status;

    typedef enum logic {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_OSCAN, OP_FINIT, OP_FSCAN, OP_AGRANT,
        OP_RDEC, OP_SHDN, OP_SHUP, OP_INS, OP_BAD, OP_NOROOM, OP_UNKNOWN, OP_OUT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_OSCAN, S_ODEC, S_FSCAN, S_FDEC,
        S_SHDN, S_SHUP, S_INS, S_DONE
    } t_state;

    typedef struct packed {
        t_dp_op op;
        logic   in_ready;
    } t_dp_cmd;

    typedef struct packed {
        logic cfg_fire;
        logic in_fire;
        logic clr_last;
        logic item_bad;
        logic is_rel;
        logic own_stop;
        logic found;
        logic slot_ok;
        logic count_zero;
        logic f_stop;
        logic cur_vld;
        logic a_erase;
        logic rd_shdn;
        logic rd_shup;
        logic shdn_done;
        logic shup_done;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
        logic [CAP_W-1:0] s;
        logic [CAP_W-1:0] e;
    } t_own_word;

    typedef struct packed {
        logic [CAP_W-1:0] s;
        logic [CAP_W-1:0] e;
    } t_free_word;

endpackage

>>> rtl/ffsa_if.sv
// ----------------------------------------------------------------------------
// ffsa channel interfaces
// Valid/ready channels for request words, result words and capacity writes.
// ----------------------------------------------------------------------------
interface ffsa_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [ffsa_pkg::KEY_W-1:0]  owner_id;
    logic [ffsa_pkg::CAP_W-1:0]  length;
    modport source (output valid, action, owner_id, length, input ready);
    modport sink   (input valid, action, owner_id, length, output ready);
endinterface

interface ffsa_out_if;
    logic                          valid;
    logic                          ready;
    logic [ffsa_pkg::STATUS_W-1:0] status;
    logic [ffsa_pkg::CAP_W-1:0]    start_slot;
    modport source (output valid, status, start_slot, input ready);
    modport sink   (input valid, status, start_slot, output ready);
endinterface

interface ffsa_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ffsa_pkg::CAP_W-1:0] capacity;
    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

>>> rtl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer: walks each request word through owner scan, free-list scan, update
// and list shifting, one datapath op per cycle unless the output is still full.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffsa_pkg::t_dp_sts i_sts,
    output ffsa_pkg::t_dp_cmd o_cmd
);
    import ffsa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.op       = OP_LOAD;
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_fire) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.item_bad) begin
                    o_cmd.op = OP_BAD;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_OSCAN;
                end
            end
            S_OSCAN: begin
                o_cmd.op = OP_OSCAN;
                if (i_sts.own_stop) n_state = S_ODEC;
            end
            S_ODEC: begin
                if (i_sts.is_rel) begin
                    if (!i_sts.found) begin
                        o_cmd.op = OP_UNKNOWN;
                        n_state  = S_DONE;
                    end else begin
                        // drop the owner record, then find its place in the list
                        o_cmd.op = OP_FINIT;
                        n_state  = i_sts.count_zero ? S_FDEC : S_FSCAN;
                    end
                end else if (!i_sts.slot_ok || i_sts.count_zero) begin
                    o_cmd.op = OP_NOROOM;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_FINIT;
                    n_state  = S_FSCAN;
                end
            end
            S_FSCAN: begin
                o_cmd.op = OP_FSCAN;
                if (i_sts.f_stop) n_state = S_FDEC;
            end
            S_FDEC: begin
                if (i_sts.is_rel) begin
                    o_cmd.op = OP_RDEC;
                    if (i_sts.rd_shdn)      n_state = S_SHDN;
                    else if (i_sts.rd_shup) n_state = S_SHUP;
                    else                    n_state = S_DONE;
                end else if (!i_sts.cur_vld) begin
                    o_cmd.op = OP_NOROOM;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_AGRANT;
                    n_state  = i_sts.a_erase ? S_SHDN : S_DONE;
                end
            end
            S_SHDN: begin
                o_cmd.op = OP_SHDN;
                if (i_sts.shdn_done) n_state = S_DONE;
            end
            S_SHUP: begin
                o_cmd.op = OP_SHUP;
                if (i_sts.shup_done) n_state = S_INS;
            end
            S_INS: begin
                o_cmd.op = OP_INS;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
        // a capacity write restarts the allocator from any state
        if (i_sts.cfg_fire) n_state = S_CLEAR;
    end

endmodule

>>> rtl/ffsa_dp.sv
// ----------------------------------------------------------------------------
// ffsa_dp
// Datapath: owner table and free-range list memories, scan pointers,
// captured ranges, capacity register and the result output register.
// ----------------------------------------------------------------------------
module ffsa_dp #(
    parameter int MAX_FREE_RANGES = ffsa_pkg::MAX_FREE_RANGES,
    parameter int MAX_OWNERS      = ffsa_pkg::MAX_OWNERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffsa_pkg::t_dp_cmd i_cmd,
    output ffsa_pkg::t_dp_sts o_sts,
    ffsa_in_if.sink           i_in,
    ffsa_cfg_if.sink          i_cfg,
    ffsa_out_if.source        o_out
);
    import ffsa_pkg::*;

    localparam int OA = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int FA = (MAX_FREE_RANGES > 1) ? $clog2(MAX_FREE_RANGES) : 1;
    localparam int FC = $clog2(MAX_FREE_RANGES + 1);

    // memories
    t_own_word  r_own_mem [MAX_OWNERS];
    t_free_word r_fr_mem  [MAX_FREE_RANGES];

    logic       own_re, own_we, fr_re, fr_we;
    logic [OA-1:0] own_raddr, own_waddr;
    logic [FA-1:0] fr_raddr, fr_waddr;
    t_own_word  own_wdata;
    t_free_word fr_wdata;

    t_own_word     r_ord;
    logic          r_ord_vld;
    logic [OA-1:0] r_ord_idx;
    t_free_word    r_frd;
    logic          r_frd_vld;
    logic [FA-1:0] r_frd_idx;

    // item and working registers
    t_action          r_action;
    logic [KEY_W-1:0] r_key;
    logic [CAP_W-1:0] r_len;
    logic [CAP_W-1:0] r_cap;
    logic [FC-1:0]    r_count;
    logic [OA:0]      r_oidx;
    logic             r_found, r_has_empty;
    logic [OA-1:0]    r_fidx, r_eidx;
    logic [CAP_W-1:0] r_s, r_e;
    logic [FC-1:0]    r_fi, r_p;
    logic             r_has_prev, r_cur_vld, r_up_more;
    t_free_word       r_prev, r_cur;
    t_status          r_status;
    logic [CAP_W-1:0] r_start;
    logic             r_ovalid;
    logic [STATUS_W-1:0] r_ostatus;
    logic [CAP_W-1:0]    r_ostart;

    logic             own_hit, own_last, f_last, a_fit, r_lt, left, right;
    logic             in_fire, cfg_fire, count_full;
    logic [CAP_W-1:0] ns, cap_sat;
    logic [OA-1:0]    slot;
    logic [FA-1:0]    p_addr, pm1_addr;

    assign in_fire    = i_in.valid && i_in.ready;
    assign cfg_fire   = i_cfg.valid && i_cfg.ready;
    assign i_in.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_ovalid;
    assign o_out.status     = r_ostatus;
    assign o_out.start_slot = r_ostart;

    assign own_hit   = r_ord_vld && r_ord.vld && (r_ord.key == r_key);
    assign own_last  = r_ord_vld && (r_ord_idx == OA'(MAX_OWNERS - 1));
    assign f_last    = r_frd_vld && (FC'(r_frd_idx) == r_count - FC'(1));
    assign a_fit     = (r_frd.e - r_frd.s) >= r_len;
    assign r_lt      = r_frd.s < r_e;
    assign ns        = r_cur.s + r_len;
    assign left      = r_has_prev && (r_prev.e == r_s);
    assign right     = r_cur_vld && (r_cur.s == r_e);
    assign slot      = r_found ? r_fidx : r_eidx;
    assign p_addr    = r_p[FA-1:0];
    assign pm1_addr  = p_addr - FA'(1);
    assign count_full = r_count >= FC'(MAX_FREE_RANGES);

    always_comb begin
        if (i_cfg.capacity == '0)                         cap_sat = CAP_W'(1);
        else if (i_cfg.capacity > CAP_W'(MAX_SLOTS))      cap_sat = CAP_W'(MAX_SLOTS);
        else                                              cap_sat = i_cfg.capacity;
    end

    // memory port control per op
    always_comb begin
        own_re    = 1'b0;
        own_raddr = r_oidx[OA-1:0];
        own_we    = 1'b0;
        own_waddr = r_oidx[OA-1:0];
        own_wdata = '0;
        fr_re     = 1'b0;
        fr_raddr  = r_fi[FA-1:0];
        fr_we     = 1'b0;
        fr_waddr  = p_addr;
        fr_wdata  = '0;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                own_we   = 1'b1;
                fr_we    = 1'b1;
                fr_waddr = '0;
                fr_wdata = '{s: CAP_W'(1), e: r_cap + CAP_W'(1)};
            end
            OP_OSCAN: own_re = r_oidx < (OA+1)'(MAX_OWNERS);
            OP_FINIT: begin
                if (r_action == ACT_RELEASE) begin
                    own_we    = 1'b1;
                    own_waddr = r_fidx;
                    own_wdata = '{vld: 1'b0, key: r_key, s: r_s, e: r_e};
                end
            end
            OP_FSCAN: fr_re = r_fi < r_count;
            OP_AGRANT: begin
                own_we    = 1'b1;
                own_waddr = slot;
                own_wdata = '{vld: 1'b1, key: r_key, s: r_cur.s, e: ns};
                fr_we     = 1'b1;
                fr_wdata  = '{s: ns, e: r_cur.e};
            end
            OP_RDEC: begin
                if (left && right) begin
                    fr_we    = 1'b1;
                    fr_waddr = pm1_addr;
                    fr_wdata = '{s: r_prev.s, e: r_cur.e};
                end else if (left) begin
                    fr_we    = 1'b1;
                    fr_waddr = pm1_addr;
                    fr_wdata = '{s: r_prev.s, e: r_e};
                end else if (right) begin
                    fr_we    = 1'b1;
                    fr_wdata = '{s: r_s, e: r_cur.e};
                end else if (!count_full && (r_p == r_count)) begin
                    fr_we    = 1'b1;
                    fr_wdata = '{s: r_s, e: r_e};
                end
            end
            OP_SHDN: begin
                fr_re    = r_fi <= r_count;
                fr_we    = r_frd_vld;
                fr_waddr = r_frd_idx - FA'(1);
                fr_wdata = r_frd;
            end
            OP_SHUP: begin
                fr_re    = r_up_more;
                fr_we    = r_frd_vld;
                fr_waddr = r_frd_idx + FA'(1);
                fr_wdata = r_frd;
            end
            OP_INS: begin
                fr_we    = 1'b1;
                fr_wdata = '{s: r_s, e: r_e};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (own_we) r_own_mem[own_waddr] <= own_wdata;
        if (own_re) r_ord <= r_own_mem[own_raddr];
        r_ord_idx <= own_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) r_fr_mem[fr_waddr] <= fr_wdata;
        if (fr_re) r_frd <= r_fr_mem[fr_raddr];
        r_frd_idx <= fr_raddr;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_W'(CAP_RESET);
            r_count   <= FC'(1);
            r_oidx    <= '0;
            r_ord_vld <= 1'b0;
            r_frd_vld <= 1'b0;
            r_ovalid  <= 1'b0;
            r_up_more <= 1'b0;
        end else begin
            r_ord_vld <= own_re;
            r_frd_vld <= fr_re;
            if (i_cmd.op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_fire) begin
                r_cap   <= cap_sat;
                r_count <= FC'(1);
                r_oidx  <= '0;
            end else begin
                case (i_cmd.op)
                    OP_CLEAR: r_oidx <= r_oidx + (OA+1)'(1);
                    OP_LOAD:  r_oidx <= '0;
                    OP_OSCAN: if (own_re) r_oidx <= r_oidx + (OA+1)'(1);
                    OP_AGRANT: if (ns == r_cur.e) r_count <= r_count - FC'(1);
                    OP_RDEC: begin
                        if (left && right) begin
                            r_count <= r_count - FC'(1);
                        end else if (!left && !right && !count_full) begin
                            if (r_p == r_count) begin
                                r_count <= r_count + FC'(1);
                            end else begin
                                r_up_more <= 1'b1;
                            end
                        end
                    end
                    OP_SHUP: if (r_up_more && (r_fi == r_p)) r_up_more <= 1'b0;
                    OP_INS:  r_count <= r_count + FC'(1);
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                if (in_fire) begin
                    r_action <= t_action'(i_in.action);
                    r_key    <= i_in.owner_id;
                    r_len    <= i_in.length;
                end
                r_found     <= 1'b0;
                r_has_empty <= 1'b0;
            end
            OP_OSCAN: begin
                if (own_hit && !r_found) begin
                    r_found <= 1'b1;
                    r_fidx  <= r_ord_idx;
                    r_s     <= r_ord.s;
                    r_e     <= r_ord.e;
                end
                if (r_ord_vld && !r_ord.vld && !r_has_empty) begin
                    r_has_empty <= 1'b1;
                    r_eidx      <= r_ord_idx;
                end
            end
            OP_FINIT: begin
                r_fi       <= '0;
                r_p        <= '0;
                r_has_prev <= 1'b0;
                r_cur_vld  <= 1'b0;
            end
            OP_FSCAN: begin
                if (fr_re) r_fi <= r_fi + FC'(1);
                if (r_frd_vld) begin
                    if (r_action == ACT_ALLOC) begin
                        if (a_fit) begin
                            r_p       <= FC'(r_frd_idx);
                            r_cur     <= r_frd;
                            r_cur_vld <= 1'b1;
                        end
                    end else if (r_lt) begin
                        r_prev     <= r_frd;
                        r_has_prev <= 1'b1;
                        if (f_last) r_p <= r_count;
                    end else begin
                        r_p       <= FC'(r_frd_idx);
                        r_cur     <= r_frd;
                        r_cur_vld <= 1'b1;
                    end
                end
            end
            OP_AGRANT: begin
                r_status <= ST_ALLOCATED;
                r_start  <= r_cur.s;
                r_fi     <= r_p + FC'(1);
            end
            OP_RDEC: begin
                r_status <= ST_RELEASED;
                r_start  <= r_s;
                if (left && right) r_fi <= r_p + FC'(1);
                else               r_fi <= r_count - FC'(1);
            end
            OP_SHDN: if (fr_re) r_fi <= r_fi + FC'(1);
            OP_SHUP: if (r_up_more) r_fi <= r_fi - FC'(1);
            OP_BAD: begin
                r_status <= ST_BAD_LENGTH;
                r_start  <= '0;
            end
            OP_NOROOM: begin
                r_status <= ST_NO_ROOM;
                r_start  <= '0;
            end
            OP_UNKNOWN: begin
                r_status <= ST_UNKNOWN;
                r_start  <= '0;
            end
            OP_OUT: begin
                r_ostatus <= r_status;
                r_ostart  <= r_start;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.cfg_fire   = cfg_fire;
        o_sts.in_fire    = in_fire;
        o_sts.clr_last   = r_oidx == (OA+1)'(MAX_OWNERS - 1);
        o_sts.item_bad   = (r_action == ACT_ALLOC) && (r_len == '0);
        o_sts.is_rel     = r_action == ACT_RELEASE;
        o_sts.own_stop   = own_hit || own_last;
        o_sts.found      = r_found;
        o_sts.slot_ok    = r_found || r_has_empty;
        o_sts.count_zero = r_count == '0;
        o_sts.f_stop     = r_frd_vld && ((r_action == ACT_ALLOC) ? (a_fit || f_last)
                                                                 : (!r_lt || f_last));
        o_sts.cur_vld    = r_cur_vld;
        o_sts.a_erase    = ns == r_cur.e;
        o_sts.rd_shdn    = left && right;
        o_sts.rd_shup    = !left && !right && !count_full && (r_p != r_count);
        o_sts.shdn_done  = r_frd_vld ? (FC'(r_frd_idx) == r_count) : (r_fi > r_count);
        o_sts.shup_done  = r_frd_vld && (FC'(r_frd_idx) == r_p);
        o_sts.out_free   = !r_ovalid || o_out.ready;
    end

endmodule

>>> rtl/first_fit_slot_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_slot_allocator
// First-fit allocator of slots 1..capacity with a coalescing free-range list.
// ----------------------------------------------------------------------------
// Channels: i_in carries request words (action, owner_id, length), o_out
// carries one result word (status, start_slot) per request, i_cfg writes the
// capacity and is always ready; a write restarts the allocator.
// After reset and after every capacity write a clearing pass walks the whole
// owner table, one entry a cycle, with i_in held not ready.
// One request at a time: a bad length skips the scans; others pass through
// the owner scan (which ends at the first matching owner) and, unless it
// fails, the free-list scan, and a shift of the free list when a range is
// erased or inserted.
// The result waits in an output register: the next request is accepted while
// it is stalled, and that request finishes only once the register is taken.
// ----------------------------------------------------------------------------
module first_fit_slot_allocator #(
    parameter int MAX_FREE_RANGES = ffsa_pkg::MAX_FREE_RANGES,
    parameter int MAX_OWNERS      = ffsa_pkg::MAX_OWNERS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffsa_in_if.sink    i_in,
    ffsa_cfg_if.sink   i_cfg,
    ffsa_out_if.source o_out
);
    import ffsa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    ffsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ffsa_dp #(
        .MAX_FREE_RANGES (MAX_FREE_RANGES),
        .MAX_OWNERS      (MAX_OWNERS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

>>> tb/tb_ffsa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ffsa_if
// Testbench-side note: channel interfaces come from the RTL interface file;
// this file holds the small shared types for queued request and result words.
// ----------------------------------------------------------------------------
package tb_ffsa_pkg;
    import ffsa_pkg::*;

    typedef struct {
        t_action          action;
        logic [KEY_W-1:0] owner_id;
        logic [CAP_W-1:0] length;
    } t_req;

    typedef struct {
        t_status          status;
        logic [CAP_W-1:0] start_slot;
    } t_res;
endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives allocate and release words and capacity writes into the slot allocator,
// keeps its own free list and owner table, and checks each result word in order.
// ----------------------------------------------------------------------------
module tb;
    import ffsa_pkg::*;
    import tb_ffsa_pkg::*;

    localparam int WATCHDOG = 400000;

    logic i_clk;
    logic i_rst_n;

    ffsa_in_if  in_ch();
    ffsa_out_if out_ch();
    ffsa_cfg_if cfg_ch();

    first_fit_slot_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    // shadow allocator state
    int unsigned      fr_s[$];
    int unsigned      fr_e[$];
    logic [KEY_W-1:0] own_key[MAX_OWNERS];
    int unsigned      own_s[MAX_OWNERS];
    int unsigned      own_e[MAX_OWNERS];
    bit               own_vld[MAX_OWNERS];

    t_req req_q[$];
    t_res result_q[$];
    int   mismatches;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_cycles;
    bit   timed_out;
    int   quiet_cycles;
    bit   in_taken;
    logic [KEY_W-1:0] held_ids[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void restart_shadow(int unsigned cap);
        fr_s.delete();
        fr_e.delete();
        fr_s.insert(0, 1);
        fr_e.insert(0, cap + 1);
        foreach (own_vld[i]) own_vld[i] = 1'b0;
    endfunction

    function automatic int find_owner(logic [KEY_W-1:0] key);
        for (int i = 0; i < MAX_OWNERS; i++)
            if (own_vld[i] && own_key[i] == key) return i;
        return -1;
    endfunction

    function automatic t_res allocate_or_release(t_req r);
        t_res res;
        int   slot;
        int unsigned s, e, p;
        bit   lt, rt;
        res.status = ST_NO_ROOM;
        res.start_slot = '0;
        slot = find_owner(r.owner_id);
        if (r.action == ACT_ALLOC) begin
            if (r.length == 0) begin
                res.status = ST_BAD_LENGTH;
                return res;
            end
            if (slot < 0)
                for (int i = 0; i < MAX_OWNERS; i++)
                    if (!own_vld[i]) begin
                        slot = i;
                        break;
                    end
            if (slot < 0) return res;
            for (int i = 0; i < fr_s.size(); i++) begin
                if (fr_e[i] - fr_s[i] >= r.length) begin
                    s = fr_s[i];
                    own_key[slot] = r.owner_id;
                    own_s[slot] = s;
                    own_e[slot] = s + r.length;
                    own_vld[slot] = 1'b1;
                    fr_s[i] = s + r.length;
                    if (fr_s[i] == fr_e[i]) begin
                        fr_s.delete(i);
                        fr_e.delete(i);
                    end
                    res.status = ST_ALLOCATED;
                    res.start_slot = s[CAP_W-1:0];
                    return res;
                end
            end
            return res;
        end
        if (slot < 0) begin
            res.status = ST_UNKNOWN;
            return res;
        end
        s = own_s[slot];
        e = own_e[slot];
        own_vld[slot] = 1'b0;
        p = 0;
        while (p < fr_s.size() && fr_s[p] < e) p++;
        lt = p > 0 && fr_e[p-1] == s;
        rt = p < fr_s.size() && fr_s[p] == e;
        if (lt && rt) begin
            fr_e[p-1] = fr_e[p];
            fr_s.delete(p);
            fr_e.delete(p);
        end else if (lt) begin
            fr_e[p-1] = e;
        end else if (rt) begin
            fr_s[p] = s;
        end else if (fr_s.size() < MAX_FREE_RANGES) begin
            fr_s.insert(p, s);
            fr_e.insert(p, e);
        end
        res.status = ST_RELEASED;
        res.start_slot = s[CAP_W-1:0];
        return res;
    endfunction

    // driver: hold the word until it is taken, then offer the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (req_q.size() > 0 && ($urandom_range(99) >= send_idle_pct)) begin
                in_ch.valid    <= 1'b1;
                in_ch.action   <= req_q[0].action;
                in_ch.owner_id <= req_q[0].owner_id;
                in_ch.length   <= req_q[0].length;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // pop the request at the accepting edge and predict its result
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            result_q.insert(result_q.size(), allocate_or_release(req_q.pop_front()));
        end
    end

    // receiver stall pattern, with a long hold-off counted here
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles  <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d start %0d",
                             out_ch.status, out_ch.start_slot);
            end else begin
                exp_res = result_q.pop_front();
                if (out_ch.status !== exp_res.status ||
                    out_ch.start_slot !== exp_res.start_slot) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d start %0d, got %0d %0d",
                                 exp_res.status, exp_res.start_slot,
                                 out_ch.status, out_ch.start_slot);
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) timed_out = 1'b1;
        end
    end

    function automatic void push_req(t_action act, logic [KEY_W-1:0] id,
                                     logic [CAP_W-1:0] len);
        t_req r;
        r.action = act;
        r.owner_id = id;
        r.length = len;
        req_q.insert(req_q.size(), r);
    endfunction

    task automatic wait_drained();
        while (req_q.size() > 0 || in_ch.valid || result_q.size() > 0) begin
            @(posedge i_clk);
            if (timed_out) return;
        end
        // allow the block to finish any trailing work
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        int unsigned v;
        @(negedge i_clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= cap;
        do @(posedge i_clk); while (!cfg_ch.ready);
        v = cap;
        if (v < 1) v = 1;
        if (v > MAX_SLOTS) v = MAX_SLOTS;
        restart_shadow(v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // random phase: mostly allocate/release of live owners, some noise
    task automatic random_words(int count, int cap);
        logic [KEY_W-1:0] id;
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            if (k < 45) begin
                id = (k < 40) ? KEY_W'($urandom_range(40)) : KEY_W'($urandom);
                push_req(ACT_ALLOC, id,
                         (k < 2) ? CAP_W'($urandom) : CAP_W'($urandom_range(cap / 8 + 1)));
                held_ids.insert(held_ids.size(), id);
            end else if (k < 85 && held_ids.size() > 0) begin
                k = $urandom_range(held_ids.size() - 1);
                push_req(ACT_RELEASE, held_ids[k], CAP_W'($urandom));
                held_ids.delete(k);
            end else begin
                push_req(t_action'($urandom_range(1)), KEY_W'($urandom),
                         CAP_W'($urandom_range(3)));
            end
        end
    endtask

    initial begin
        mismatches    = 0;
        timed_out     = 1'b0;
        hold_cycles   = 0;
        send_idle_pct = 29;
        recv_idle_pct = 64;
        quiet_cycles  = 0;
        in_ch.valid    = 1'b0;
        in_ch.action   = 1'b0;
        in_ch.owner_id = '0;
        in_ch.length   = '0;
        out_ch.ready   = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = '0;
        restart_shadow(CAP_RESET);
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset capacity, extremes, every status
        push_req(ACT_ALLOC, 16'h0000, 11'd0);
        push_req(ACT_ALLOC, 16'hFFFF, 11'd1);
        push_req(ACT_ALLOC, 16'h0001, 11'd1024);
        push_req(ACT_ALLOC, 16'h0001, 11'd2047);
        push_req(ACT_ALLOC, 16'h0002, 11'd3);
        push_req(ACT_ALLOC, 16'h0002, 11'd5);
        push_req(ACT_RELEASE, 16'h1234, 11'h7FF);
        push_req(ACT_ALLOC, 16'h0003, 11'd4);
        push_req(ACT_RELEASE, 16'h0002, 11'd0);
        push_req(ACT_RELEASE, 16'hFFFF, 11'd0);
        push_req(ACT_RELEASE, 16'h0003, 11'd0);
        push_req(ACT_ALLOC, 16'h0004, 11'd1000);
        push_req(ACT_RELEASE, 16'h0004, 11'd0);
        wait_drained();

        // full capacity fill, then free list fragmentation
        write_capacity(11'd1024);
        push_req(ACT_ALLOC, 16'hAAAA, 11'd1024);
        push_req(ACT_ALLOC, 16'h5555, 11'd1);
        push_req(ACT_RELEASE, 16'hAAAA, 11'd0);
        random_words(380, 1024);
        wait_drained();
        held_ids.delete();

        write_capacity(11'd0);
        push_req(ACT_ALLOC, 16'h0010, 11'd1);
        push_req(ACT_ALLOC, 16'h0011, 11'd1);
        push_req(ACT_RELEASE, 16'h0010, 11'd0);
        wait_drained();

        write_capacity(11'h7FF);
        send_idle_pct = 64;
        recv_idle_pct = 29;
        random_words(380, 1024);
        hold_cycles = 5000;
        wait_drained();
        held_ids.delete();

        write_capacity(11'd37);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_words(380, 37);
        wait_drained();

        if (timed_out) begin
            $display("Testbench completed WITH ERRORS");
        end else if (mismatches == 0 && result_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
